### hw/rtl/scd_pkg.sv
// Package for the shifted cosine evaluator: item structs, pipeline tag,
// operation and register codes, phase constants and CORDIC table functions.
// No dependencies.
package scd_pkg;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] sample_x;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_y;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic       valid;
        logic [1:0] op;
        logic       flip;
    } t_tag;

    localparam logic [1:0] OP_VALUE  = 2'd0;
    localparam logic [1:0] OP_FIRST  = 2'd1;
    localparam logic [1:0] OP_SECOND = 2'd2;

    localparam logic [1:0] REG_OFFSET_A    = 2'd0;
    localparam logic [1:0] REG_AMPLITUDE_B = 2'd1;
    localparam logic [1:0] REG_FREQUENCY_C = 2'd2;
    localparam logic [1:0] REG_PHASE_D     = 2'd3;

    localparam int RED_STEPS = 30;
    localparam int PHASE_LAT = RED_STEPS + 6;
    localparam int POST_LAT  = 6;

    localparam logic [35:0] TWO_PI_Q32  = 36'h6487ED511;
    localparam logic [35:0] PI_Q32      = 36'h3243F6A89;
    localparam logic [35:0] HALF_PI_Q32 = 36'h1921FB544;

    localparam logic [63:0] QUARTER_PI_Q62 = 64'h3243F6A8885A308D;
    localparam logic [63:0] INV_SQRT2_Q62  = 64'h2D413CCCFE779921;
    localparam logic [63:0] ONE_Q62        = 64'h4000000000000000;

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Restoring division; returns the quotient in the upper half and the
    // remainder in the lower half.
    function automatic logic [127:0] udivmod64(input logic [63:0] num,
                                               input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int bi = 63; bi >= 0; bi--) begin
            r = {r[63:0], num[bi]};
            if (r >= {1'b0, den}) begin
                r = r - {1'b0, den};
                q[bi] = 1'b1;
            end
        end
        return {q, r[63:0]};
    endfunction

    function automatic logic [63:0] atan_q62(input int i);
        logic [63:0] at;
        logic [63:0] term;
        logic [127:0] qr;
        int k;
        int n;
        int e;
        logic done;
        at = '0;
        if (i == 0) begin
            at = QUARTER_PI_Q62;
        end else begin
            k = 0;
            done = 1'b0;
            while (!done) begin
                n = 2 * k + 1;
                e = 62 - i * n;
                if (e < 0) begin
                    done = 1'b1;
                end else begin
                    qr = udivmod64(64'd1 << e, 64'(n));
                    term = qr[127:64];
                    if (k[0]) at = at - term;
                    else at = at + term;
                    k = k + 1;
                end
            end
        end
        return at;
    endfunction

    function automatic logic [63:0] gain_q62(input int stages);
        logic [63:0] g;
        logic [63:0] f;
        logic [63:0] t;
        logic [63:0] den;
        logic [63:0] num;
        logic [127:0] qr;
        logic [127:0] qr2;
        int k;
        logic done;
        g = INV_SQRT2_Q62;
        for (int i = 1; i < stages; i++) begin
            f = ONE_Q62;
            t = ONE_Q62;
            k = 1;
            done = 1'b0;
            while (!done) begin
                den = 64'(2 * k);
                num = den - 64'd1;
                t = (2 * i >= 63) ? 64'd0 : (t >> (2 * i));
                qr = udivmod64(t, den);
                qr2 = udivmod64(qr[63:0] * num, den);
                t = qr[127:64] * num + qr2[127:64];
                if (t == 64'd0) begin
                    done = 1'b1;
                end else begin
                    if (k[0]) f = f - t;
                    else f = f + t;
                    k = k + 1;
                end
            end
            g = mul_q62(g, f);
        end
        return g;
    endfunction

    function automatic logic [63:0] q62_to_frac(input logic [63:0] v, input int frac);
        int s;
        s = 62 - frac;
        if (s == 0) return v;
        return (v + (64'd1 << (s - 1))) >> s;
    endfunction

endpackage

### hw/rtl/scd_phase.sv
// Phase pipeline: forms c*x + d, reduces it modulo 2*pi, folds it into
// [-pi/2, pi/2] and scales it to the CORDIC angle format. Uses scd_pkg.
module scd_phase import scd_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_tag                      i_tag,
    input  logic signed [31:0]        i_x,
    input  logic signed [31:0]        i_c,
    input  logic signed [31:0]        i_d,
    output t_tag                      o_tag,
    output logic signed [DATA_WIDTH:0] o_z
);

    localparam int FRAC = DATA_WIDTH - 2;
    localparam int EW   = DATA_WIDTH + 40;

    localparam logic signed [35:0] S_TWO_PI  = TWO_PI_Q32;
    localparam logic signed [35:0] S_PI      = PI_Q32;
    localparam logic signed [35:0] S_HALF_PI = HALF_PI_Q32;

    t_tag               r_tag1;
    t_tag               r_tag2;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_theta;

    logic [63:0] r_rem  [0:RED_STEPS];
    logic        r_neg  [0:RED_STEPS];
    t_tag        r_rtag [0:RED_STEPS];

    t_tag               r_utag;
    t_tag               r_ftag;
    t_tag               r_ztag;
    logic signed [35:0] r_r0;
    logic signed [35:0] r_fold;
    logic signed [DATA_WIDTH:0] r_z;

    logic [35:0]          rem_lo;
    logic signed [35:0]   n_r0;
    logic signed [35:0]   n_fold;
    logic                 n_flip;
    logic signed [EW-1:0] ext;
    logic signed [EW-1:0] n_zw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1    <= '0;
            r_tag2    <= '0;
            r_rtag[0] <= '0;
        end else begin
            r_tag1    <= i_tag;
            r_tag2    <= r_tag1;
            r_rtag[0] <= r_tag2;
        end
        r_prod    <= i_c * i_x;
        r_theta   <= r_prod + $signed({{16{i_d[31]}}, i_d, 16'd0});
        r_neg[0]  <= r_theta[63];
        r_rem[0]  <= r_theta[63] ? 64'(-r_theta) : 64'(r_theta);
    end

    for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
        localparam logic [64:0] K = 65'(TWO_PI_Q32) << (RED_STEPS - 1 - j);
        logic [63:0] n_rem;

        always_comb begin
            n_rem = ({1'b0, r_rem[j]} >= K) ? (r_rem[j] - K[63:0]) : r_rem[j];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rtag[j+1] <= '0;
            end else begin
                r_rtag[j+1] <= r_rtag[j];
            end
            r_rem[j+1] <= n_rem;
            r_neg[j+1] <= r_neg[j];
        end
    end

    assign rem_lo = r_rem[RED_STEPS][35:0];

    always_comb begin
        if (r_neg[RED_STEPS] && rem_lo != '0) n_r0 = $signed(TWO_PI_Q32 - rem_lo);
        else n_r0 = $signed(rem_lo);
    end

    always_comb begin
        n_fold = r_r0;
        n_flip = 1'b0;
        if (n_fold > S_PI) n_fold = n_fold - S_TWO_PI;
        if (n_fold > S_HALF_PI) begin
            n_fold = n_fold - S_PI;
            n_flip = 1'b1;
        end else if (n_fold < -S_HALF_PI) begin
            n_fold = n_fold + S_PI;
            n_flip = 1'b1;
        end
    end

    assign ext = EW'(r_fold);

    if (FRAC >= 32) begin : g_zup
        assign n_zw = ext <<< (FRAC - 32);
    end else begin : g_zdn
        localparam logic signed [EW-1:0] ZRND = EW'(1) << (31 - FRAC);
        assign n_zw = (ext + ZRND) >>> (32 - FRAC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_utag <= '0;
            r_ftag <= '0;
            r_ztag <= '0;
        end else begin
            r_utag <= r_rtag[RED_STEPS];
            r_ftag <= '{valid: r_utag.valid, op: r_utag.op, flip: n_flip};
            r_ztag <= r_ftag;
        end
        r_r0   <= n_r0;
        r_fold <= n_fold;
        r_z    <= n_zw[DATA_WIDTH:0];
    end

    assign o_tag = r_ztag;
    assign o_z   = r_z;

endmodule

### hw/rtl/scd_cordic.sv
// Rotation-mode CORDIC, one register stage per iteration, conversion of cosine
// and sine to Q2.30, rounded if narrowed, and the quadrant flip. Uses scd_pkg.
module scd_cordic import scd_pkg::*; #(
    parameter int DATA_WIDTH    = 32,
    parameter int CORDIC_STAGES = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_tag                       i_tag,
    input  logic signed [DATA_WIDTH:0] i_z,
    output t_tag                       o_tag,
    output logic signed [31:0]         o_cos,
    output logic signed [31:0]         o_sin
);

    localparam int W    = DATA_WIDTH + 1;
    localparam int RW   = W + 1;
    localparam int FRAC = DATA_WIDTH - 2;
    localparam int N    = CORDIC_STAGES;
    localparam logic signed [W-1:0] GAIN = W'(q62_to_frac(gain_q62(N), FRAC));

    logic signed [W-1:0] r_x   [0:N];
    logic signed [W-1:0] r_y   [0:N];
    logic signed [W-1:0] r_z   [0:N];
    t_tag                r_tag [0:N];

    t_tag               r_otag;
    logic signed [31:0] r_cos;
    logic signed [31:0] r_sin;
    logic signed [31:0] n_cos;
    logic signed [31:0] n_sin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0] <= '0;
        end else begin
            r_tag[0] <= i_tag;
        end
        r_x[0] <= GAIN;
        r_y[0] <= '0;
        r_z[0] <= i_z;
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam logic signed [W-1:0] ANG = W'(q62_to_frac(atan_q62(i), FRAC));
        logic signed [W-1:0] xs;
        logic signed [W-1:0] ys;
        logic signed [W-1:0] n_x;
        logic signed [W-1:0] n_y;
        logic signed [W-1:0] n_z;

        always_comb begin
            xs = r_x[i] >>> i;
            ys = r_y[i] >>> i;
            if (!r_z[i][W-1]) begin
                n_x = r_x[i] - ys;
                n_y = r_y[i] + xs;
                n_z = r_z[i] - ANG;
            end else begin
                n_x = r_x[i] + ys;
                n_y = r_y[i] - xs;
                n_z = r_z[i] + ANG;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[i+1] <= '0;
            end else begin
                r_tag[i+1] <= r_tag[i];
            end
            r_x[i+1] <= n_x;
            r_y[i+1] <= n_y;
            r_z[i+1] <= n_z;
        end
    end

    logic signed [31:0] cos_q30;
    logic signed [31:0] sin_q30;

    if (FRAC > 30) begin : g_rnd
        localparam logic signed [RW-1:0] RND = RW'(1) << (FRAC - 31);
        logic signed [RW-1:0] cw;
        logic signed [RW-1:0] sw;
        assign cw = (RW'(r_x[N]) + RND) >>> (FRAC - 30);
        assign sw = (RW'(r_y[N]) + RND) >>> (FRAC - 30);
        assign cos_q30 = cw[31:0];
        assign sin_q30 = sw[31:0];
    end else if (FRAC == 30) begin : g_same
        assign cos_q30 = r_x[N][31:0];
        assign sin_q30 = r_y[N][31:0];
    end else begin : g_up
        assign cos_q30 = 32'(r_x[N]) <<< (30 - FRAC);
        assign sin_q30 = 32'(r_y[N]) <<< (30 - FRAC);
    end

    assign n_cos = r_tag[N].flip ? -cos_q30 : cos_q30;
    assign n_sin = r_tag[N].flip ? -sin_q30 : sin_q30;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_otag <= '0;
        end else begin
            r_otag <= r_tag[N];
        end
        r_cos <= n_cos;
        r_sin <= n_sin;
    end

    assign o_tag = r_otag;
    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

### hw/rtl/shifted_cosine_and_derivatives_top.sv
// Top level of the shifted cosine evaluator: configuration registers, phase
// and CORDIC pipelines, and the scaling, rounding and saturation stages.
// Uses scd_pkg, scd_phase and scd_cordic.
//
//   channel   ports                                   handshake
//   input     start, busy, i_item                     start && !busy
//   result    o_valid, o_item                         o_valid, one cycle
//   config    i_wr_en, i_wr_index, i_wr_data          i_wr_en
//
// One item is accepted every cycle; busy is always low.
// The phase reduction takes one modulo step per stage over RED_STEPS stages,
// the CORDIC one register stage per iteration, followed by the scaling stages.
// Synchronous reset clears the valid bits and the configuration registers to zero.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module shifted_cosine_and_derivatives_top import scd_pkg::*; #(
    parameter int DATA_WIDTH    = 32,
    parameter int CORDIC_STAGES = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  t_in_item    i_item,
    output logic        busy,
    output logic        o_valid,
    output t_out_item   o_item,
    input  logic        i_wr_en,
    input  logic [1:0]  i_wr_index,
    input  logic [31:0] i_wr_data
);

    localparam int LAT = PHASE_LAT + CORDIC_STAGES + 2 + POST_LAT;

    logic signed [31:0] r_a;
    logic signed [31:0] r_b;
    logic signed [31:0] r_c;
    logic signed [31:0] r_d;

    logic [31:0] r_bm;
    logic [31:0] r_cm;
    logic [63:0] r_p1;
    logic [63:0] r_p2h;
    logic [63:0] r_p2l;
    logic [95:0] r_p2;

    t_tag                      in_tag;
    t_tag                      ph_tag;
    logic signed [DATA_WIDTH:0] ph_z;
    t_tag                      cd_tag;
    logic signed [31:0]        cd_cos;
    logic signed [31:0]        cd_sin;

    t_tag r_tag_e1, r_tag_e2, r_tag_e3, r_tag_e4, r_tag_e5, r_otag;
    logic [2:0] r_neg_e1, r_neg_e2, r_neg_e3, r_neg_e4;

    logic [31:0]  r_csm;
    logic [31:0]  r_snm;
    logic [63:0]  r_ppa, r_pps0, r_pps1, r_ppc0, r_ppc1, r_ppc2;
    logic [63:0]  r_sum0;
    logic [95:0]  r_sum1;
    logic [127:0] r_sum2;
    logic [33:0]  r_mag0;
    logic [63:0]  r_mag1;
    logic [63:0]  r_mag2;
    logic signed [63:0] r_val;
    t_out_item    r_out;

    logic [64:0]  n_m0;
    logic [127:0] n_m1;
    logic [127:0] n_m2;
    logic signed [63:0] n_val;
    t_out_item    n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
            r_b <= '0;
            r_c <= '0;
            r_d <= '0;
        end else if (i_wr_en) begin
            case (i_wr_index)
                REG_OFFSET_A:    r_a <= i_wr_data;
                REG_AMPLITUDE_B: r_b <= i_wr_data;
                REG_FREQUENCY_C: r_c <= i_wr_data;
                REG_PHASE_D:     r_d <= i_wr_data;
                default: ;
            endcase
        end
    end

    // Coefficient products depend on configuration only and settle long
    // before an item reaches the scaling stages.
    always_ff @(posedge i_clk) begin
        r_bm  <= r_b[31] ? 32'(-r_b) : 32'(r_b);
        r_cm  <= r_c[31] ? 32'(-r_c) : 32'(r_c);
        r_p1  <= 64'(r_bm) * 64'(r_cm);
        r_p2h <= 64'(r_p1[63:32]) * 64'(r_cm);
        r_p2l <= 64'(r_p1[31:0]) * 64'(r_cm);
        r_p2  <= {r_p2h, 32'd0} + 96'(r_p2l);
    end

    assign busy   = 1'b0;
    assign in_tag = '{valid: start && !busy, op: i_item.operation, flip: 1'b0};

    scd_phase #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (in_tag),
        .i_x     (i_item.sample_x),
        .i_c     (r_c),
        .i_d     (r_d),
        .o_tag   (ph_tag),
        .o_z     (ph_z)
    );

    scd_cordic #(
        .DATA_WIDTH    (DATA_WIDTH),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (ph_tag),
        .i_z     (ph_z),
        .o_tag   (cd_tag),
        .o_cos   (cd_cos),
        .o_sin   (cd_sin)
    );

    assign n_m0 = 65'(r_sum0) + (65'd1 << 29);
    assign n_m1 = 128'(r_sum1) + (128'd1 << 45);
    assign n_m2 = r_sum2 + (128'd1 << 61);

    always_comb begin
        case (r_tag_e4.op)
            OP_VALUE:  n_val = 64'(r_a) + (r_neg_e4[0] ? -64'(r_mag0) : 64'(r_mag0));
            OP_FIRST:  n_val = r_neg_e4[1] ? -r_mag1 : r_mag1;
            OP_SECOND: n_val = r_neg_e4[2] ? -r_mag2 : r_mag2;
            default:   n_val = '0;
        endcase
    end

    always_comb begin
        if (r_val > 64'sh000000007FFFFFFF) begin
            n_out = '{result_y: 32'sh7FFFFFFF, saturated: 1'b1};
        end else if (r_val < -64'sh0000000080000000) begin
            n_out = '{result_y: 32'sh80000000, saturated: 1'b1};
        end else begin
            n_out = '{result_y: r_val[31:0], saturated: 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_e1 <= '0;
            r_tag_e2 <= '0;
            r_tag_e3 <= '0;
            r_tag_e4 <= '0;
            r_tag_e5 <= '0;
            r_otag   <= '0;
        end else begin
            r_tag_e1 <= cd_tag;
            r_tag_e2 <= r_tag_e1;
            r_tag_e3 <= r_tag_e2;
            r_tag_e4 <= r_tag_e3;
            r_tag_e5 <= r_tag_e4;
            r_otag   <= r_tag_e5;
        end
        r_csm    <= cd_cos[31] ? 32'(-cd_cos) : 32'(cd_cos);
        r_snm    <= cd_sin[31] ? 32'(-cd_sin) : 32'(cd_sin);
        r_neg_e1 <= {r_b[31] == cd_cos[31],
                     (r_b[31] ^ r_c[31]) == cd_sin[31],
                     r_b[31] != cd_cos[31]};
        r_ppa    <= 64'(r_bm) * 64'(r_csm);
        r_pps0   <= 64'(r_p1[31:0]) * 64'(r_snm);
        r_pps1   <= 64'(r_p1[63:32]) * 64'(r_snm);
        r_ppc0   <= 64'(r_p2[31:0]) * 64'(r_csm);
        r_ppc1   <= 64'(r_p2[63:32]) * 64'(r_csm);
        r_ppc2   <= 64'(r_p2[95:64]) * 64'(r_csm);
        r_neg_e2 <= r_neg_e1;
        r_sum0   <= r_ppa;
        r_sum1   <= 96'(r_pps0) + {r_pps1, 32'd0};
        r_sum2   <= 128'(r_ppc0) + {32'd0, r_ppc1, 32'd0} + {r_ppc2, 64'd0};
        r_neg_e3 <= r_neg_e2;
        r_mag0   <= n_m0[63:30];
        r_mag1   <= n_m1[109:46];
        r_mag2   <= n_m2[125:62];
        r_neg_e4 <= r_neg_e3;
        r_val    <= n_val;
        r_out    <= n_out;
    end

    assign o_valid = r_otag.valid;
    assign o_item  = r_out;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without a matching accepted item");

    a_unused_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_otag.op != OP_VALUE && r_otag.op != OP_FIRST &&
         r_otag.op != OP_SECOND) |-> (o_item.result_y == '0 && !o_item.saturated))
        else $error("unused operation gave a nonzero result");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.saturated) |->
        (o_item.result_y == 32'sh7FFFFFFF || o_item.result_y == 32'sh80000000))
        else $error("saturated result is not at a bound");

endmodule
